// ===== design/csb_pkg.sv =====
package csb_pkg;

    typedef enum logic [1:0] {
        ACT_INIT    = 2'd0,
        ACT_ACQUIRE = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ID  = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input word
        logic rd_entry;  // read semaphore entry (registered)
        logic clr_step;  // clear one slot of the ring, advance pointer
        logic scan_step; // examine one slot, advance pointer
        logic finish;    // write back and emit result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic bad_id;
        logic is_init;
        logic need_scan;  // release with count still <= 0
        logic last_slot;  // pointer at final slot / final scan step
        logic hit;        // current scanned slot is occupied
        logic sweep;      // slot memory clearing pass after reset
    } t_stat;

    localparam int COUNT_W = 16;
    localparam int PROC_W  = 6;

endpackage

// ===== design/csb_ctrl.sv =====
module csb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  csb_pkg::t_stat i_stat,
    output csb_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import csb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                // held busy until the slot memory sweep after reset ends
                o_busy = i_stat.sweep;
                if (i_start && !i_stat.sweep) begin
                    o_cmd.load = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_entry = 1'b1;
                if (i_stat.bad_id) begin
                    n_state = S_DONE;
                end else if (i_stat.is_init) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.last_slot) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (!i_stat.need_scan) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.hit || i_stat.last_slot) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_stat.sweep) |-> !o_busy)
        else $error("busy while idle");
    a_finish_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE))
        else $error("no return to idle after finish");
    a_load_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_READ))
        else $error("load not followed by entry read");

endmodule

// ===== design/csb_datapath.sv =====
module csb_datapath #(
    parameter int NUM_SEMS   = 16,
    parameter int RING_SLOTS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csb_pkg::t_cmd                 i_cmd,
    input  logic [1:0]                    i_action,
    input  logic [7:0]                    i_sem_id,
    input  logic signed [15:0]            i_init_value,
    input  logic [5:0]                    i_proc_id,
    output csb_pkg::t_stat                o_stat,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic                          o_must_wait,
    output logic                          o_wake_valid,
    output logic [5:0]                    o_wake_proc
);
    import csb_pkg::*;

    localparam int SEM_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int IDX_W  = $clog2(RING_SLOTS);
    localparam int SLOT_W = SEM_W + IDX_W;
    // each ring row padded to a power of two so a slot address is {sem, index}
    localparam int TOTAL  = NUM_SEMS << IDX_W;

    // per-semaphore entry store; used bits for reset value
    logic [COUNT_W-1:0] r_cnt_mem  [NUM_SEMS];
    logic [IDX_W-1:0]   r_head_mem [NUM_SEMS];
    logic [IDX_W-1:0]   r_tail_mem [NUM_SEMS];
    logic [NUM_SEMS-1:0] r_ent_vld;
    // slot store: occupancy and waiter ids
    logic               r_used_mem [TOTAL];
    logic [PROC_W-1:0]  r_proc_mem [TOTAL];

    logic [1:0]         r_action;
    logic [SEM_W-1:0]   r_sem;
    logic               r_bad;
    logic [COUNT_W-1:0] r_initv;
    logic [PROC_W-1:0]  r_proc;

    logic signed [COUNT_W-1:0] r_cnt;
    logic [IDX_W-1:0]   r_head, r_tail, r_ptr;
    logic [IDX_W:0]     r_steps;
    logic               r_used_q;
    logic [PROC_W-1:0]  r_proc_q;
    logic               r_found, r_rd_q;
    logic [IDX_W-1:0]   r_found_idx;
    logic [PROC_W-1:0]  r_found_proc;
    logic [SLOT_W:0]    r_rst_ptr;

    logic signed [COUNT_W-1:0] dec_v, inc_v;
    logic [IDX_W-1:0]   nt, ptr_nx, ptr_pv;
    logic [SLOT_W-1:0]  rd_addr, slot_at_ptr;
    logic               scan_live;
    logic               acq_ok;

    logic signed [COUNT_W-1:0] n_cnt;
    logic [IDX_W-1:0]   n_head, n_tail;
    t_status            n_status;
    logic               n_must_wait, n_wake_valid;
    logic [PROC_W-1:0]  n_wake_proc;

    assign dec_v = (r_cnt == -16'sd32768) ? r_cnt : r_cnt - 16'sd1;
    assign inc_v = (r_cnt == 16'sd32767) ? r_cnt : r_cnt + 16'sd1;
    assign nt = (r_tail == IDX_W'(RING_SLOTS - 1)) ? '0 : r_tail + 1'b1;
    assign ptr_nx = (r_ptr == IDX_W'(RING_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
    assign ptr_pv = (r_ptr == '0) ? IDX_W'(RING_SLOTS - 1) : r_ptr - 1'b1;
    assign slot_at_ptr = {r_sem, r_ptr};
    assign acq_ok = (r_action == ACT_ACQUIRE) && (dec_v < 0) && (nt != r_head);

    // scan reads slot ptr registered: r_rd_q marks data of previous ptr
    assign scan_live = r_rd_q;

    always_comb begin
        o_stat = '0;
        o_stat.bad_id    = r_bad;
        o_stat.is_init   = (r_action == ACT_INIT);
        o_stat.need_scan = (r_action == ACT_RELEASE) && (inc_v <= 0);
        o_stat.hit       = scan_live && r_used_q;
        o_stat.last_slot = (r_action == ACT_INIT) ? (r_ptr == IDX_W'(RING_SLOTS - 1))
                                                  : (r_steps == (IDX_W+1)'(RING_SLOTS));
        o_stat.sweep     = (r_rst_ptr != (SLOT_W+1)'(TOTAL));
    end

    assign rd_addr = slot_at_ptr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_bad    <= ({1'b0, i_sem_id} >= 9'(NUM_SEMS));
            r_sem    <= SEM_W'(i_sem_id);
            r_initv  <= i_init_value;
            r_proc   <= i_proc_id;
        end
        if (i_cmd.rd_entry) begin
            r_cnt  <= r_ent_vld[r_sem] ? r_cnt_mem[r_sem]  : '0;
            r_head <= r_ent_vld[r_sem] ? r_head_mem[r_sem] : '0;
            r_tail <= r_ent_vld[r_sem] ? r_tail_mem[r_sem] : '0;
            // init clears the whole ring from slot 0
            r_ptr  <= (r_action == ACT_INIT || !r_ent_vld[r_sem]) ? '0
                                                                   : r_head_mem[r_sem];
        end
        if (i_cmd.clr_step) begin
            r_ptr <= ptr_nx;
        end
        // slot read port, one per cycle
        r_used_q <= r_used_mem[rd_addr];
        r_proc_q <= r_proc_mem[rd_addr];
        if (i_cmd.scan_step) begin
            if (!r_rd_q || !r_used_q) begin
                r_ptr <= ptr_nx;
            end
            if (r_rd_q && r_used_q) begin
                r_found_proc <= r_proc_q;
                r_found_idx  <= ptr_pv;
            end
        end
    end

    // step counter, read-valid and found flags, done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_q  <= 1'b0;
            r_steps <= '0;
            r_found <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            o_done <= i_cmd.finish;
            if (i_cmd.rd_entry) begin
                r_rd_q  <= 1'b0;
                r_steps <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_rd_q  <= 1'b1;
                if (r_rd_q) begin
                    r_steps <= r_steps + 1'b1;
                end
                if (r_rd_q && r_used_q) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_ptr <= '0;
        end else if (r_rst_ptr != (SLOT_W+1)'(TOTAL)) begin
            r_rst_ptr <= r_rst_ptr + 1'b1;
        end
    end

    // slot store writes
    always_ff @(posedge i_clk) begin
        if (r_rst_ptr != (SLOT_W+1)'(TOTAL)) begin
            r_used_mem[r_rst_ptr[SLOT_W-1:0]] <= 1'b0;
        end else if (i_cmd.clr_step) begin
            r_used_mem[slot_at_ptr] <= 1'b0;
        end else if (i_cmd.finish && !r_bad && acq_ok) begin
            r_used_mem[{r_sem, r_tail}] <= 1'b1;
        end else if (i_cmd.finish && !r_bad && r_action == ACT_RELEASE && r_found) begin
            r_used_mem[{r_sem, r_found_idx}] <= 1'b0;
        end
        if (i_cmd.finish && !r_bad && acq_ok) begin
            r_proc_mem[{r_sem, r_tail}] <= r_proc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (i_cmd.finish && !r_bad) begin
            r_ent_vld[r_sem] <= 1'b1;
        end
    end

    // entry write-back values and result
    always_comb begin
        n_cnt        = r_cnt;
        n_head       = r_head;
        n_tail       = r_tail;
        n_status     = ST_OK;
        n_must_wait  = 1'b0;
        n_wake_valid = 1'b0;
        n_wake_proc  = '0;
        if (r_bad) begin
            n_status = ST_BAD_ID;
        end else begin
            unique case (r_action)
                ACT_INIT: begin
                    n_cnt  = r_initv;
                    n_head = '0;
                    n_tail = '0;
                end
                ACT_ACQUIRE: begin
                    if (dec_v >= 0) begin
                        n_cnt = dec_v;
                    end else if (acq_ok) begin
                        n_cnt       = dec_v;
                        n_tail      = nt;
                        n_must_wait = 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                ACT_RELEASE: begin
                    if (inc_v > 0) begin
                        n_cnt = inc_v;
                    end else if (r_found) begin
                        n_cnt        = inc_v;
                        n_head       = r_found_idx;
                        n_wake_valid = 1'b1;
                        n_wake_proc  = r_found_proc;
                    end else begin
                        n_status = ST_EMPTY;
                    end
                end
                ACT_NONE: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && !r_bad) begin
            r_cnt_mem[r_sem]  <= n_cnt;
            r_head_mem[r_sem] <= n_head;
            r_tail_mem[r_sem] <= n_tail;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status     <= n_status;
            o_must_wait  <= n_must_wait;
            o_wake_valid <= n_wake_valid;
            o_wake_proc  <= n_wake_proc;
        end
    end

    a_wait_wake_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_must_wait && o_wake_valid))
        else $error("wait and wake in one result");
    a_found_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_found) |-> (r_action == ACT_RELEASE))
        else $error("waiter found outside release");
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_BAD_ID) |-> (!o_must_wait && !o_wake_valid))
        else $error("bad id result carries flags");

endmodule

// ===== design/counting_semaphore_bank_top.sv =====
// Bank of counting semaphores with waiter rings. Raise start while busy is
// low to issue one word; its result appears on the o_ ports for one cycle with
// o_done high and cannot be held off. After the accepting edge the entry is
// read; init then clears every ring slot in turn, acquire and a release that
// needs no scan leave the scan state at once, and any other release scans the
// ring through the slot memory, one read per cycle with registered data, up to
// the first occupied slot or the ring end; the done state registers the result.
// After reset a pass clears all NUM_SEMS times RING_SLOTS (rounded up to a
// power of two) occupancy memory entries; busy stays high until it ends.
module counting_semaphore_bank_top #(
    parameter int NUM_SEMS   = 16,
    parameter int RING_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_sem_id,
    input  logic signed [15:0] i_init_value,
    input  logic [5:0]  i_proc_id,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_must_wait,
    output logic        o_wake_valid,
    output logic [5:0]  o_wake_proc
);
    import csb_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    csb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    csb_datapath #(
        .NUM_SEMS   (NUM_SEMS),
        .RING_SLOTS (RING_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_sem_id     (i_sem_id),
        .i_init_value (i_init_value),
        .i_proc_id    (i_proc_id),
        .o_stat       (stat),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_must_wait  (o_must_wait),
        .o_wake_valid (o_wake_valid),
        .o_wake_proc  (o_wake_proc)
    );

endmodule
